FILE: design/rvpd_pkg.sv
// Package for the RISC-V instruction predecoder: opcodes, flow kind codes,
// length codes and the decode result struct. No dependencies.
`timescale 1ns / 1ps

package rvpd_pkg;

    localparam int AddrWidth = 64;
    localparam int WordWidth = 32;

    // Major opcodes of the 32-bit encodings
    localparam logic [6:0] OPC_JAL    = 7'h6F;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_OPIMM  = 7'h13;
    localparam logic [6:0] OPC_OPIMMW = 7'h1B;
    localparam logic [6:0] OPC_OP     = 7'h33;
    localparam logic [6:0] OPC_OPW    = 7'h3B;
    localparam logic [6:0] OPC_SYSTEM = 7'h73;
    localparam logic [6:0] OPC_MISC   = 7'h0F;
    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;

    // Flow kinds
    localparam logic [2:0] KIND_OTHER  = 3'd0;
    localparam logic [2:0] KIND_CALL   = 3'd1;
    localparam logic [2:0] KIND_JUMP   = 3'd2;
    localparam logic [2:0] KIND_BRANCH = 3'd3;
    localparam logic [2:0] KIND_RETURN = 3'd4;

    // Instruction lengths in bytes
    localparam logic [2:0] LEN_NONE = 3'd0;
    localparam logic [2:0] LEN_HALF = 3'd2;
    localparam logic [2:0] LEN_FULL = 3'd4;

    typedef struct packed {
        logic                 legal;
        logic [2:0]           insn_length;
        logic [2:0]           flow_kind;
        logic [AddrWidth-1:0] branch_target;
        logic                 target_known;
    } pd_result_t;

endpackage

FILE: design/rvpd_decode.sv
// Combinational predecode of one fetch word: length, legality, flow kind
// and target. Depends on rvpd_pkg.
`timescale 1ns / 1ps

module rvpd_decode (
    input  logic [rvpd_pkg::WordWidth-1:0] word,
    input  logic [2:0]                     avail,
    input  logic [rvpd_pkg::AddrWidth-1:0] addr,
    input  logic                           rv64,
    output rvpd_pkg::pd_result_t           result
);

    localparam int ADDR_WIDTH = rvpd_pkg::AddrWidth;

    logic [15:0] hw;
    logic [1:0]  cq;
    logic [2:0]  cf3;
    logic [4:0]  crd;
    logic [4:0]  crs2;
    logic [1:0]  cf2;
    logic        cb12;
    logic [11:0] coffj;
    logic [8:0]  coffb;
    logic        leg16;
    logic [2:0]  kind16;
    logic        known16;
    logic [ADDR_WIDTH-1:0] off16;

    logic [6:0]  opc;
    logic [4:0]  rd;
    logic [2:0]  f3;
    logic [4:0]  rs1;
    logic [6:0]  f7;
    logic [5:0]  f6;
    logic [11:0] immi;
    logic [12:0] offb;
    logic [20:0] offj;
    logic        leg32;
    logic [2:0]  kind32;
    logic        known32;
    logic        abs32;
    logic [ADDR_WIDTH-1:0] off32;

    logic        compressed;
    logic        ge2;
    logic        ge4;
    logic        leg;
    logic        known;
    logic [ADDR_WIDTH-1:0] base;
    logic [ADDR_WIDTH-1:0] offset;
    logic [ADDR_WIDTH-1:0] target;

    assign hw    = word[15:0];
    assign cq    = hw[1:0];
    assign cf3   = hw[15:13];
    assign crd   = hw[11:7];
    assign crs2  = hw[6:2];
    assign cf2   = hw[11:10];
    assign cb12  = hw[12];
    assign coffj = {hw[12], hw[8], hw[10], hw[9], hw[6], hw[7], hw[2], hw[11], hw[5:3], 1'b0};
    assign coffb = {hw[12], hw[6:5], hw[2], hw[11:10], hw[4:3], 1'b0};

    // Compressed quadrants
    always_comb
    begin
        leg16   = 1'b0;
        kind16  = rvpd_pkg::KIND_OTHER;
        known16 = 1'b0;
        off16   = {ADDR_WIDTH{1'b0}};
        unique case (cq)
            2'd0:
            begin
                unique case (cf3)
                    3'd0:        leg16 = (hw[12:5] != 8'd0);
                    3'd2, 3'd6:  leg16 = 1'b1;
                    3'd3, 3'd7:  leg16 = rv64;
                    default:     leg16 = 1'b0;
                endcase
            end
            2'd1:
            begin
                unique case (cf3)
                    3'd0, 3'd2:  leg16 = 1'b1;
                    3'd1:
                    begin
                        if (rv64)
                        begin
                            leg16 = (crd != 5'd0);
                        end
                        else
                        begin
                            // c.jal exists only in RV32
                            leg16   = 1'b1;
                            kind16  = rvpd_pkg::KIND_CALL;
                            known16 = 1'b1;
                            off16   = {{(ADDR_WIDTH-12){coffj[11]}}, coffj};
                        end
                    end
                    3'd3:        leg16 = (crd != 5'd0) && (cb12 || (hw[6:2] != 5'd0));
                    3'd4:
                    begin
                        if (!cf2[1])
                        begin
                            leg16 = rv64 || !cb12;
                        end
                        else if (cf2 == 2'd2)
                        begin
                            leg16 = 1'b1;
                        end
                        else if (!cb12)
                        begin
                            leg16 = 1'b1;
                        end
                        else
                        begin
                            leg16 = rv64 && !hw[6];
                        end
                    end
                    3'd5:
                    begin
                        leg16   = 1'b1;
                        kind16  = rvpd_pkg::KIND_JUMP;
                        known16 = 1'b1;
                        off16   = {{(ADDR_WIDTH-12){coffj[11]}}, coffj};
                    end
                    default:
                    begin
                        leg16   = 1'b1;
                        kind16  = rvpd_pkg::KIND_BRANCH;
                        known16 = 1'b1;
                        off16   = {{(ADDR_WIDTH-9){coffb[8]}}, coffb};
                    end
                endcase
            end
            default:
            begin
                unique case (cf3)
                    3'd0:  leg16 = (crd != 5'd0) && (rv64 || !cb12);
                    3'd2:  leg16 = (crd != 5'd0);
                    3'd3:  leg16 = rv64 && (crd != 5'd0);
                    3'd4:
                    begin
                        if (!cb12)
                        begin
                            if (crs2 == 5'd0)
                            begin
                                // c.jr; rd x0 is reserved
                                leg16  = (crd != 5'd0);
                                kind16 = (crd == 5'd1) ? rvpd_pkg::KIND_RETURN
                                                       : rvpd_pkg::KIND_JUMP;
                            end
                            else
                            begin
                                leg16 = 1'b1;
                            end
                        end
                        else
                        begin
                            leg16 = 1'b1;
                            if (crs2 == 5'd0 && crd != 5'd0)
                            begin
                                kind16 = rvpd_pkg::KIND_CALL;
                            end
                        end
                    end
                    3'd6:  leg16 = 1'b1;
                    3'd7:  leg16 = rv64;
                    default: leg16 = 1'b0;
                endcase
            end
        endcase
    end

    assign opc  = word[6:0];
    assign rd   = word[11:7];
    assign f3   = word[14:12];
    assign rs1  = word[19:15];
    assign f7   = word[31:25];
    assign f6   = word[31:26];
    assign immi = word[31:20];
    assign offb = {word[31], word[7], word[30:25], word[11:8], 1'b0};
    assign offj = {word[31], word[19:12], word[20], word[30:21], 1'b0};

    // Full-width encodings
    always_comb
    begin
        leg32   = 1'b0;
        kind32  = rvpd_pkg::KIND_OTHER;
        known32 = 1'b0;
        abs32   = 1'b0;
        off32   = {ADDR_WIDTH{1'b0}};
        unique case (opc)
            rvpd_pkg::OPC_LUI, rvpd_pkg::OPC_AUIPC:  leg32 = 1'b1;
            rvpd_pkg::OPC_JAL:
            begin
                leg32   = 1'b1;
                kind32  = (rd == 5'd0) ? rvpd_pkg::KIND_JUMP : rvpd_pkg::KIND_CALL;
                known32 = 1'b1;
                off32   = {{(ADDR_WIDTH-21){offj[20]}}, offj};
            end
            rvpd_pkg::OPC_JALR:
            begin
                leg32 = (f3 == 3'd0);
                if (rs1 == 5'd0)
                begin
                    // base x0: immediate is an absolute target
                    kind32  = rvpd_pkg::KIND_JUMP;
                    known32 = 1'b1;
                    abs32   = 1'b1;
                    off32   = {{(ADDR_WIDTH-12){immi[11]}}, immi};
                end
                else if (rd == 5'd0 && rs1 == 5'd1)
                begin
                    kind32 = rvpd_pkg::KIND_RETURN;
                end
                else if (rd == 5'd1)
                begin
                    kind32 = rvpd_pkg::KIND_CALL;
                end
                else
                begin
                    kind32 = rvpd_pkg::KIND_JUMP;
                end
            end
            rvpd_pkg::OPC_BRANCH:
            begin
                leg32   = (f3 != 3'd2) && (f3 != 3'd3);
                kind32  = rvpd_pkg::KIND_BRANCH;
                known32 = 1'b1;
                off32   = {{(ADDR_WIDTH-13){offb[12]}}, offb};
            end
            rvpd_pkg::OPC_LOAD:
            begin
                if (f3 == 3'd7)
                begin
                    leg32 = 1'b0;
                end
                else if (f3 == 3'd3 || f3 == 3'd6)
                begin
                    leg32 = rv64;
                end
                else
                begin
                    leg32 = 1'b1;
                end
            end
            rvpd_pkg::OPC_STORE:  leg32 = (f3 < 3'd3) || (f3 == 3'd3 && rv64);
            rvpd_pkg::OPC_OPIMM:
            begin
                if (f3 == 3'd1)
                begin
                    leg32 = rv64 ? (f6 == 6'h00) : (f7 == 7'h00);
                end
                else if (f3 == 3'd5)
                begin
                    leg32 = rv64 ? (f6 == 6'h00 || f6 == 6'h10)
                                 : (f7 == 7'h00 || f7 == 7'h20);
                end
                else
                begin
                    leg32 = 1'b1;
                end
            end
            rvpd_pkg::OPC_OPIMMW:
            begin
                if (f3 == 3'd0)
                begin
                    leg32 = rv64;
                end
                else if (f3 == 3'd1)
                begin
                    leg32 = rv64 && (f7 == 7'h00);
                end
                else if (f3 == 3'd5)
                begin
                    leg32 = rv64 && (f7 == 7'h00 || f7 == 7'h20);
                end
                else
                begin
                    leg32 = 1'b0;
                end
            end
            rvpd_pkg::OPC_OP:
            begin
                leg32 = (f7 == 7'h00) || (f7 == 7'h01) ||
                        (f7 == 7'h20 && (f3 == 3'd0 || f3 == 3'd5));
            end
            rvpd_pkg::OPC_OPW:
            begin
                if (f7 == 7'h01)
                begin
                    leg32 = rv64 && (f3 == 3'd0 || f3 >= 3'd4);
                end
                else if (f7 == 7'h00)
                begin
                    leg32 = rv64 && (f3 == 3'd0 || f3 == 3'd1 || f3 == 3'd5);
                end
                else if (f7 == 7'h20)
                begin
                    leg32 = rv64 && (f3 == 3'd0 || f3 == 3'd5);
                end
                else
                begin
                    leg32 = 1'b0;
                end
            end
            rvpd_pkg::OPC_MISC:    leg32 = (f3 <= 3'd1);
            rvpd_pkg::OPC_SYSTEM:  leg32 = (f3 == 3'd0) ? (rs1 == 5'd0) : (f3 != 3'd4);
            default:               leg32 = 1'b0;
        endcase
    end

    assign compressed = (word[1:0] != 2'b11);
    assign ge2        = (avail >= 3'd2);
    assign ge4        = (avail >= 3'd4);

    assign leg    = compressed ? (ge2 && leg16) : (ge4 && leg32);
    assign known  = leg && (compressed ? known16 : known32);
    assign base   = (!compressed && abs32) ? {ADDR_WIDTH{1'b0}} : addr;
    assign offset = compressed ? off16 : off32;
    assign target = base + offset;

    always_comb
    begin
        result.legal = leg;
        if (compressed)
        begin
            result.insn_length = ge2 ? rvpd_pkg::LEN_HALF : rvpd_pkg::LEN_NONE;
        end
        else
        begin
            result.insn_length = ge4 ? rvpd_pkg::LEN_FULL : rvpd_pkg::LEN_NONE;
        end
        if (leg)
        begin
            result.flow_kind = compressed ? kind16 : kind32;
        end
        else
        begin
            result.flow_kind = rvpd_pkg::KIND_OTHER;
        end
        result.target_known  = known;
        result.branch_target = known ? target : {ADDR_WIDTH{1'b0}};
    end

endmodule

FILE: design/riscv_instruction_predecoder.sv
// Top level of the RISC-V instruction predecoder: input register, decode,
// result register and the rv64_mode register. Depends on rvpd_pkg, rvpd_decode.
`timescale 1ns / 1ps

// One fetch word is taken on every clock edge with start high; busy never
// rises, so a new word may follow each cycle. The decode of a word sits
// between the input register and the result register, which puts its result
// on the result ports with done high, for one cycle only. The receiver
// cannot stall: take every result beat in the cycle that done marks it.
// rv64_mode resets to 1 and is written by cfg_write_en with cfg_write_data;
// write it only while no word is in flight.
module riscv_instruction_predecoder (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [rvpd_pkg::WordWidth-1:0] fetch_word,
    input  logic [2:0]                     bytes_available,
    input  logic [rvpd_pkg::AddrWidth-1:0] fetch_address,
    input  logic                           cfg_write_en,
    input  logic                           cfg_write_data,
    output logic                           done,
    output logic                           legal,
    output logic [2:0]                     insn_length,
    output logic [2:0]                     flow_kind,
    output logic [rvpd_pkg::AddrWidth-1:0] branch_target,
    output logic                           target_known
);

    logic                           rv64_mode_reg;
    logic                           in_valid_reg;
    logic [rvpd_pkg::WordWidth-1:0] word_reg;
    logic [2:0]                     avail_reg;
    logic [rvpd_pkg::AddrWidth-1:0] addr_reg;
    logic                           out_valid_reg;
    rvpd_pkg::pd_result_t           result_next;
    rvpd_pkg::pd_result_t           result_reg;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rv64_mode_reg <= 1'b1;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                rv64_mode_reg <= cfg_write_data;
            end
            in_valid_reg  <= start && !busy;
            out_valid_reg <= in_valid_reg;
        end
    end

    // Payload registers: load on every beat, no reset
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            word_reg  <= fetch_word;
            avail_reg <= bytes_available;
            addr_reg  <= fetch_address;
        end
        if (in_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    rvpd_decode u_decode (
        .word   (word_reg),
        .avail  (avail_reg),
        .addr   (addr_reg),
        .rv64   (rv64_mode_reg),
        .result (result_next)
    );

    assign done          = out_valid_reg;
    assign legal         = result_reg.legal;
    assign insn_length   = result_reg.insn_length;
    assign flow_kind     = result_reg.flow_kind;
    assign branch_target = result_reg.branch_target;
    assign target_known  = result_reg.target_known;

endmodule

FILE: design/rvpd_checker.sv
// Port-level assertions for the RISC-V instruction predecoder and the bind
// that attaches them. Depends on rvpd_pkg and riscv_instruction_predecoder.
`timescale 1ns / 1ps

module rvpd_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           start,
    input logic                           busy,
    input logic                           done,
    input logic                           legal,
    input logic [2:0]                     insn_length,
    input logic [2:0]                     flow_kind,
    input logic [rvpd_pkg::AddrWidth-1:0] branch_target,
    input logic                           target_known
);

    // The block never holds off a fetch word
    assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    // Every accepted beat yields a result once it has passed the input and result registers
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |-> ##2 done)
        else $error("result missing two cycles after accept");

    // No result without an earlier accepted beat
    assert property (@(posedge clk) disable iff (!rst_n) done |-> $past(start && !busy, 2))
        else $error("result without accepted beat");

    // A known target belongs only to a legal direct transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && target_known) |-> (legal && (flow_kind == rvpd_pkg::KIND_CALL ||
            flow_kind == rvpd_pkg::KIND_JUMP || flow_kind == rvpd_pkg::KIND_BRANCH)))
        else $error("known target on a non-direct transfer");

    // Too few bytes clears every other field
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && insn_length == rvpd_pkg::LEN_NONE) |->
            (!legal && flow_kind == rvpd_pkg::KIND_OTHER && !target_known &&
             branch_target == {rvpd_pkg::AddrWidth{1'b0}}))
        else $error("short fetch word produced a decode");

endmodule

bind riscv_instruction_predecoder rvpd_checker u_rvpd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .done          (done),
    .legal         (legal),
    .insn_length   (insn_length),
    .flow_kind     (flow_kind),
    .branch_target (branch_target),
    .target_known  (target_known)
);
